// ===== rtl/fkp_pkg.sv =====
// ============================================================================
// fkp_pkg: shared types, codes and helpers for the forward kinematics core
// Q-format word types, request codes, sequencer states and saturation.
// ============================================================================
`default_nettype none

package fkp_pkg;

    // default sizes
    localparam int JOINTS_DEF    = 64;
    localparam int FRAC_BITS_DEF = 16;

    // one Q value, one matrix row, one 4x4 matrix
    typedef logic signed [31:0] q_t;
    typedef q_t [3:0]           qrow_t;
    typedef q_t [15:0]          qmat_t;

    // rounded product / accumulator width
    typedef logic signed [63:0] wide_t;
    typedef wide_t [3:0]        wvec_t;

    // request codes
    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_ROOT = 2'd1,
        REQ_ROT  = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_QUAT,
        ST_MAT,
        ST_SWAP,
        ST_EMIT,
        ST_HOLD
    } fkp_state_t;

    // clamp a wide value to the 32-bit Q range
    function automatic q_t sat32(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fkp_ram.sv =====
// ============================================================================
// fkp_ram: generic single-write, single-read synchronous RAM
// Read data is registered and holds while no read is issued.
// ============================================================================
`default_nettype none

module fkp_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/fkp_mac.sv =====
// ============================================================================
// fkp_mac: four-lane Q multiplier with rounding and saturating sum
// Each lane forms the exact product, rounds it to the Q grid and registers
// it; the registered lanes are summed and clamped for a matrix entry.
// ============================================================================
`default_nettype none

module fkp_mac #(
    parameter int FRAC_BITS = fkp_pkg::FRAC_BITS_DEF
) (
    input  wire logic          clk,
    input  wire fkp_pkg::qrow_t a_op,
    input  wire fkp_pkg::qrow_t b_op,
    output fkp_pkg::wvec_t     prod,
    output fkp_pkg::q_t        sat_sum
);

    import fkp_pkg::*;

    localparam wide_t HALF = wide_t'(64'sd1 <<< (FRAC_BITS - 1));

    wvec_t prod_reg;
    wide_t acc;

    // multiply, round half up (floor after adding half an LSB)
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod_reg[k] <= ((wide_t'(a_op[k]) * wide_t'(b_op[k])) + HALF) >>> FRAC_BITS;
        end
    end

    // exact sum of the rounded lanes, clamped once
    always_comb
    begin
        acc = prod_reg[0] + prod_reg[1] + prod_reg[2] + prod_reg[3];
    end

    assign prod    = prod_reg;
    assign sat_sum = sat32(acc);

endmodule

`default_nettype wire

// ===== rtl/forward_kinematics_palette_core.sv =====
// ============================================================================
// forward_kinematics_palette_core: skeletal matrix palette builder
// Stores joint offsets and parents, forms root and joint palette matrices.
// ============================================================================
// Usage:
//   Request channel (req_valid/req_ready) carries one item per transfer.
//   A load item writes one offset row (and the parent on row zero), leaves
//   the block idle and ready, and gives no response.
//   A root item emits four rows of T(p)*Ry(-yaw) for joint 0 and stores them.
//   A rotation item reads the parent palette and the offset matrix, converts
//   the quaternion, and forms palette[parent]*offset*R(q) on a four-lane
//   multiplier, one matrix entry at a time (two 16-entry products).
//   A rotation item passes the fetch, quaternion, matrix, swap and second
//   matrix states before its first row; a root item goes straight to emit.
//   The block holds one item at a time: req_ready is high only when idle.
//   A stalled response holds its row; the next row waits for the transfer.
//   Reset returns the sequencer to idle with no response pending; the
//   tables keep no reset value and must be loaded before use.
// ============================================================================
`default_nettype none

module forward_kinematics_palette_core #(
    parameter int JOINTS    = fkp_pkg::JOINTS_DEF,
    parameter int FRAC_BITS = fkp_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire logic [1:0]         req_type,
    input  wire logic [5:0]         joint_index,
    input  wire logic [5:0]         parent_index,
    input  wire logic [1:0]         row_index,
    input  wire logic signed [31:0] elem_a,
    input  wire logic signed [31:0] elem_b,
    input  wire logic signed [31:0] elem_c,
    input  wire logic signed [31:0] elem_d,
    input  wire logic signed [31:0] quat_w,
    input  wire logic signed [31:0] quat_x,
    input  wire logic signed [31:0] quat_y,
    input  wire logic signed [31:0] quat_z,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output logic [5:0]              out_joint,
    output logic [1:0]              out_row,
    output logic signed [31:0]      col_zero,
    output logic signed [31:0]      col_one,
    output logic signed [31:0]      col_two,
    output logic signed [31:0]      col_three,
    output logic                    last_row
);

    import fkp_pkg::*;

    localparam int    JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int    RW    = JW + 2;
    localparam q_t    ONE_Q = q_t'(1 << FRAC_BITS);
    localparam wide_t ONE_W = wide_t'(64'sd1 <<< FRAC_BITS);

    // quaternion product slots
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    fkp_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       second_reg, second_next;
    logic       rsp_valid_reg, rsp_valid_next;

    logic [5:0] joint_reg;
    q_t         qw_reg, qx_reg, qy_reg, qz_reg;
    qmat_t      a_reg, b_reg, r_reg;
    wide_t      qp_reg [9];

    logic [5:0] out_joint_reg;
    logic [1:0] out_row_reg;
    qrow_t      out_cols_reg;
    logic       last_row_reg;

    logic          req_fire, joint_ok, load_we;
    logic [JW-1:0] jw_in, jw_reg, par_w;
    logic [5:0]    par_raw;
    logic [RW-1:0] off_raddr, pal_raddr, pal_waddr;
    logic [4*32-1:0] off_rdata, pal_rdata;
    logic          fetch_re;
    logic [1:0]    fetch_row;
    qrow_t         emit_row, a_op, b_op;
    wvec_t         prod;
    q_t            sat_sum;
    qmat_t         rot_m, root_m;

    assign req_fire  = req_valid && req_ready;
    assign joint_ok  = 32'(joint_index) < JOINTS;
    assign jw_in     = JW'(joint_index);
    assign jw_reg    = JW'(joint_reg);
    assign par_w     = (32'(par_raw) < JOINTS) ? JW'(par_raw) : '0;
    assign load_we   = req_fire && (req_type == REQ_LOAD) && joint_ok;
    assign fetch_re  = (state_reg == ST_FETCH) && !cnt_reg[2];
    assign fetch_row = cnt_reg[1:0] - 2'd1;
    assign off_raddr = {jw_reg, cnt_reg[1:0]};
    assign pal_raddr = {par_w, cnt_reg[1:0]};
    assign pal_waddr = {jw_reg, cnt_reg[1:0]};

    // offset table, one row per entry
    fkp_ram #(.WIDTH(4 * 32), .DEPTH(JOINTS * 4)) u_off_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr ({jw_in, row_index}),
        .wdata ({elem_d, elem_c, elem_b, elem_a}),
        .re    (fetch_re),
        .raddr (off_raddr),
        .rdata (off_rdata)
    );

    // parent table, read when a rotation item is taken
    fkp_ram #(.WIDTH(6), .DEPTH(JOINTS)) u_par_ram (
        .clk   (clk),
        .we    (load_we && (row_index == 2'd0)),
        .waddr (jw_in),
        .wdata (parent_index),
        .re    (req_fire && (req_type == REQ_ROT)),
        .raddr (jw_in),
        .rdata (par_raw)
    );

    // palette, one row per entry
    fkp_ram #(.WIDTH(4 * 32), .DEPTH(JOINTS * 4)) u_pal_ram (
        .clk   (clk),
        .we    (state_reg == ST_EMIT),
        .waddr (pal_waddr),
        .wdata (emit_row),
        .re    (fetch_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    fkp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk     (clk),
        .a_op    (a_op),
        .b_op    (b_op),
        .prod    (prod),
        .sat_sum (sat_sum)
    );

    // row of the result matrix being emitted
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            emit_row[k] = r_reg[{cnt_reg[1:0], 2'(k)}];
        end
    end

    // rotation matrix from quaternion products
    always_comb
    begin
        rot_m     = '0;
        rot_m[0]  = sat32(ONE_W - ((qp_reg[P_YY] + qp_reg[P_ZZ]) <<< 1));
        rot_m[1]  = sat32((qp_reg[P_XY] - qp_reg[P_WZ]) <<< 1);
        rot_m[2]  = sat32((qp_reg[P_XZ] + qp_reg[P_WY]) <<< 1);
        rot_m[4]  = sat32((qp_reg[P_XY] + qp_reg[P_WZ]) <<< 1);
        rot_m[5]  = sat32(ONE_W - ((qp_reg[P_XX] + qp_reg[P_ZZ]) <<< 1));
        rot_m[6]  = sat32((qp_reg[P_YZ] - qp_reg[P_WX]) <<< 1);
        rot_m[8]  = sat32((qp_reg[P_XZ] - qp_reg[P_WY]) <<< 1);
        rot_m[9]  = sat32((qp_reg[P_YZ] + qp_reg[P_WX]) <<< 1);
        rot_m[10] = sat32(ONE_W - ((qp_reg[P_XX] + qp_reg[P_YY]) <<< 1));
        rot_m[15] = ONE_Q;
    end

    // root matrix T(p) * Ry(-yaw)
    always_comb
    begin
        root_m     = '0;
        root_m[0]  = quat_w;
        root_m[2]  = sat32(-wide_t'(quat_y));
        root_m[3]  = elem_a;
        root_m[5]  = ONE_Q;
        root_m[7]  = elem_b;
        root_m[8]  = quat_y;
        root_m[10] = quat_w;
        root_m[11] = elem_c;
        root_m[15] = ONE_Q;
    end

    // multiplier operand select
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            a_op[k] = a_reg[{cnt_reg[4:3], 2'(k)}];
            b_op[k] = b_reg[{2'(k), cnt_reg[2:1]}];
        end
        if (state_reg == ST_QUAT)
        begin
            case (cnt_reg[1:0])
                2'd0:
                begin
                    a_op = {qx_reg, qz_reg, qy_reg, qx_reg};
                    b_op = {qy_reg, qz_reg, qy_reg, qx_reg};
                end
                2'd1:
                begin
                    a_op = {qw_reg, qw_reg, qy_reg, qx_reg};
                    b_op = {qy_reg, qx_reg, qz_reg, qz_reg};
                end
                default:
                begin
                    a_op = {qw_reg, qw_reg, qw_reg, qw_reg};
                    b_op = {qz_reg, qz_reg, qz_reg, qz_reg};
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            second_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            second_reg    <= second_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        second_next    = second_reg;
        rsp_valid_next = rsp_valid_reg;
        req_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cnt_next  = '0;
                if (req_fire)
                begin
                    if (req_type == REQ_ROOT)
                        state_next = ST_EMIT;
                    else if ((req_type == REQ_ROT) && joint_ok)
                    begin
                        state_next  = ST_FETCH;
                        second_next = 1'b0;
                    end
                end
            end
            ST_FETCH:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd4)
                begin
                    state_next = ST_QUAT;
                    cnt_next   = '0;
                end
            end
            ST_QUAT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    state_next = ST_MAT;
                    cnt_next   = '0;
                end
            end
            ST_MAT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = second_reg ? ST_EMIT : ST_SWAP;
            end
            ST_SWAP:
            begin
                state_next  = ST_MAT;
                second_next = 1'b1;
                cnt_next    = '0;
            end
            ST_EMIT:
            begin
                rsp_valid_next = 1'b1;
                state_next     = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (rsp_ready)
                begin
                    rsp_valid_next = 1'b0;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                        cnt_next   = cnt_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    joint_reg <= (req_type == REQ_ROOT) ? 6'd0 : joint_index;
                    qw_reg    <= quat_w;
                    qx_reg    <= quat_x;
                    qy_reg    <= quat_y;
                    qz_reg    <= quat_z;
                    if (req_type == REQ_ROOT)
                        r_reg <= root_m;
                end
            end
            ST_FETCH:
            begin
                if (cnt_reg != 5'd0)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        a_reg[{fetch_row, 2'(k)}] <= pal_rdata[k*32 +: 32];
                        b_reg[{fetch_row, 2'(k)}] <= off_rdata[k*32 +: 32];
                    end
                end
            end
            ST_QUAT:
            begin
                case (cnt_reg[1:0])
                    2'd1:
                    begin
                        qp_reg[P_XX] <= prod[0];
                        qp_reg[P_YY] <= prod[1];
                        qp_reg[P_ZZ] <= prod[2];
                        qp_reg[P_XY] <= prod[3];
                    end
                    2'd2:
                    begin
                        qp_reg[P_XZ] <= prod[0];
                        qp_reg[P_YZ] <= prod[1];
                        qp_reg[P_WX] <= prod[2];
                        qp_reg[P_WY] <= prod[3];
                    end
                    2'd3:
                    begin
                        qp_reg[P_WZ] <= prod[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_MAT:
            begin
                // odd step: lanes hold the products of the entry
                if (cnt_reg[0])
                    r_reg[cnt_reg[4:1]] <= sat_sum;
            end
            ST_SWAP:
            begin
                a_reg <= r_reg;
                b_reg <= rot_m;
            end
            ST_EMIT:
            begin
                out_joint_reg <= joint_reg;
                out_row_reg   <= cnt_reg[1:0];
                out_cols_reg  <= emit_row;
                last_row_reg  <= (cnt_reg[1:0] == 2'd3);
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign out_joint = out_joint_reg;
    assign out_row   = out_row_reg;
    assign col_zero  = out_cols_reg[0];
    assign col_one   = out_cols_reg[1];
    assign col_two   = out_cols_reg[2];
    assign col_three = out_cols_reg[3];
    assign last_row  = last_row_reg;

endmodule

`default_nettype wire

// ===== rtl/fkp_checker.sv =====
// ============================================================================
// fkp_checker: port-level checks for the forward kinematics core
// Watches the request and response channels and is bound to the top level.
// ============================================================================
`default_nettype none

module fkp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic [1:0]         req_type,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic [1:0]         out_row,
    input wire logic signed [31:0] col_zero,
    input wire logic signed [31:0] col_three,
    input wire logic               last_row
);

    import fkp_pkg::*;

    // a stalled row holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_row)
            && $stable(col_zero) && $stable(col_three))
        else $error("response changed while stalled");

    // last flag marks row three
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (last_row == (out_row == 2'd3)))
        else $error("last_row does not match out_row");

    // no request taken while a row is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request ready during response");

    // mid-matrix transfer keeps the request side closed
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !last_row |=> !req_ready)
        else $error("request ready before matrix finished");

    // a load transfer leaves the block idle and ready
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == REQ_LOAD) |=> req_ready)
        else $error("load did not return to idle");

endmodule

bind forward_kinematics_palette_core fkp_checker u_fkp_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// ============================================================================
// testbench: forward kinematics palette core check
// Drives load, root, rotation and unknown transfers through the request channel,
// predicts every palette row in Q16.16 and compares each response transfer.
// ============================================================================
`timescale 1ns / 100ps

module testbench;
    import fkp_pkg::*;

    localparam int NJ         = 64;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 400;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        req_t       kind;
        logic [5:0] joint;
        logic [5:0] parent;
        logic [1:0] row;
        q_t         ea, eb, ec, ed;
        q_t         qw, qx, qy, qz;
    } fk_item_t;

    typedef struct packed {
        logic [5:0] joint;
        logic [1:0] row;
        qrow_t      cols;
        logic       last;
    } pose_row_t;

    // ------------------------------------------------------------------------
    // Palette predictor and store of expected rows
    // ------------------------------------------------------------------------
    class fk_scoreboard;
        qmat_t      offsets [NJ];
        logic [5:0] parents [NJ];
        qmat_t      poses   [NJ];
        pose_row_t  pose_rows [$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        // exact product rounded to the Q grid (half LSB up, floor)
        function longint qround(q_t a, q_t b);
            longint p;
            p = longint'(a) * longint'(b) + 64'sd32768;
            return p >>> FRAC_BITS_DEF;
        endfunction

        function q_t clamp(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648)
                return 32'sh8000_0000;
            return v[31:0];
        endfunction

        function qmat_t mat_product(qmat_t a, qmat_t b);
            qmat_t  r;
            longint acc;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < 4; k++)
                        acc += qround(a[i*4+k], b[k*4+j]);
                    r[i*4+j] = clamp(acc);
                end
            return r;
        endfunction

        function void push_matrix(logic [5:0] joint, qmat_t m);
            pose_row_t pr;
            for (int r = 0; r < 4; r++)
            begin
                pr.joint = joint;
                pr.row   = r[1:0];
                for (int k = 0; k < 4; k++)
                    pr.cols[k] = m[r*4+k];
                pr.last  = (r == 3);
                pose_rows.push_back(pr);
            end
        endfunction

        // accepted request: update tables, queue the rows it produces
        function void note_input(fk_item_t it);
            qmat_t  m, rot;
            longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
            int     p;
            longint one;
            one = 64'sd1 <<< FRAC_BITS_DEF;
            case (it.kind)
                REQ_LOAD:
                begin
                    offsets[it.joint][it.row*4+0] = it.ea;
                    offsets[it.joint][it.row*4+1] = it.eb;
                    offsets[it.joint][it.row*4+2] = it.ec;
                    offsets[it.joint][it.row*4+3] = it.ed;
                    if (it.row == 0)
                        parents[it.joint] = it.parent;
                end
                REQ_ROOT:
                begin
                    m = '0;
                    m[0]  = it.qw;
                    m[2]  = clamp(-longint'(it.qy));
                    m[3]  = it.ea;
                    m[5]  = clamp(one);
                    m[7]  = it.eb;
                    m[8]  = it.qy;
                    m[10] = it.qw;
                    m[11] = it.ec;
                    m[15] = clamp(one);
                    poses[0] = m;
                    push_matrix(6'd0, m);
                end
                REQ_ROT:
                begin
                    p  = int'(parents[it.joint]);
                    xx = qround(it.qx, it.qx); yy = qround(it.qy, it.qy);
                    zz = qround(it.qz, it.qz); xy = qround(it.qx, it.qy);
                    xz = qround(it.qx, it.qz); yz = qround(it.qy, it.qz);
                    wx = qround(it.qw, it.qx); wy = qround(it.qw, it.qy);
                    wz = qround(it.qw, it.qz);
                    rot = '0;
                    rot[0]  = clamp(one - 2 * (yy + zz));
                    rot[1]  = clamp(2 * (xy - wz));
                    rot[2]  = clamp(2 * (xz + wy));
                    rot[4]  = clamp(2 * (xy + wz));
                    rot[5]  = clamp(one - 2 * (xx + zz));
                    rot[6]  = clamp(2 * (yz - wx));
                    rot[8]  = clamp(2 * (xz - wy));
                    rot[9]  = clamp(2 * (yz + wx));
                    rot[10] = clamp(one - 2 * (xx + yy));
                    rot[15] = clamp(one);
                    m = mat_product(mat_product(poses[p], offsets[it.joint]), rot);
                    poses[it.joint] = m;
                    push_matrix(it.joint, m);
                end
                default: ;
            endcase
        endfunction

        function void check_result(pose_row_t got);
            pose_row_t want;
            if (pose_rows.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected row: joint %0d row %0d", got.joint, got.row);
                return;
            end
            want = pose_rows.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("row mismatch: exp j%0d r%0d %h %h %h %h l%0d, got j%0d r%0d %h %h %h %h l%0d",
                             want.joint, want.row, want.cols[0], want.cols[1],
                             want.cols[2], want.cols[3], want.last,
                             got.joint, got.row, got.cols[0], got.cols[1],
                             got.cols[2], got.cols[3], got.last);
            end
        endfunction

        function int pending();
            return pose_rows.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block
    // ------------------------------------------------------------------------
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    logic [1:0] req_type = 2'd0;
    logic [5:0] joint_index = '0, parent_index = '0;
    logic [1:0] row_index = '0;
    q_t         elem_a = '0, elem_b = '0, elem_c = '0, elem_d = '0;
    q_t         quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    logic [5:0] out_joint;
    logic [1:0] out_row;
    q_t         col_zero, col_one, col_two, col_three;
    logic       last_row;

    forward_kinematics_palette_core u_top (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .req_type(req_type), .joint_index(joint_index),
        .parent_index(parent_index), .row_index(row_index),
        .elem_a(elem_a), .elem_b(elem_b), .elem_c(elem_c), .elem_d(elem_d),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .out_joint(out_joint), .out_row(out_row),
        .col_zero(col_zero), .col_one(col_one), .col_two(col_two),
        .col_three(col_three), .last_row(last_row)
    );

    fk_scoreboard sb = new();

    always #10 clk = ~clk;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Response side: check transfers, drive ready
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result({out_joint, out_row,
                             {col_three, col_two, col_one, col_zero}, last_row});
        if (hold_asked != hold_seen)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_LEN;
        end
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    bit         row_loaded [NJ][4];
    bit         pose_known [NJ];
    logic [5:0] parent_of  [NJ];

    function q_t rand_q();
        if ($urandom_range(2) == 0)
            return $urandom;
        return q_t'($urandom_range(131072)) - 32'sd65536;
    endfunction

    // item with random filler in the fields it does not use
    function fk_item_t filler(req_t kind);
        fk_item_t it;
        it.kind  = kind;
        it.joint = 6'($urandom);  it.parent = 6'($urandom);  it.row = 2'($urandom);
        it.ea = $urandom; it.eb = $urandom; it.ec = $urandom; it.ed = $urandom;
        it.qw = $urandom; it.qx = $urandom; it.qy = $urandom; it.qz = $urandom;
        return it;
    endfunction

    task automatic send_item(fk_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        req_type     <= it.kind;
        joint_index  <= it.joint;
        parent_index <= it.parent;
        row_index    <= it.row;
        elem_a <= it.ea; elem_b <= it.eb; elem_c <= it.ec; elem_d <= it.ed;
        quat_w <= it.qw; quat_x <= it.qx; quat_y <= it.qy; quat_z <= it.qz;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic send_load(int j, int par, int r, q_t a, q_t b, q_t c, q_t d);
        fk_item_t it;
        it = filler(REQ_LOAD);
        it.joint = 6'(j); it.row = 2'(r);
        it.ea = a; it.eb = b; it.ec = c; it.ed = d;
        if (r == 0)
        begin
            it.parent = 6'(par);
            parent_of[j] = 6'(par);
        end
        row_loaded[j][r] = 1;
        send_item(it);
    endtask

    task automatic send_root(q_t px, q_t py, q_t pz, q_t cs, q_t sn);
        fk_item_t it;
        it = filler(REQ_ROOT);
        it.ea = px; it.eb = py; it.ec = pz; it.qw = cs; it.qy = sn;
        pose_known[0] = 1;
        send_item(it);
    endtask

    task automatic send_rot(int j, q_t w, q_t x, q_t y, q_t z);
        fk_item_t it;
        it = filler(REQ_ROT);
        it.joint = 6'(j); it.qw = w; it.qx = x; it.qy = y; it.qz = z;
        pose_known[j] = 1;
        send_item(it);
    endtask

    function bit can_rotate(int j);
        return row_loaded[j][0] && row_loaded[j][1] && row_loaded[j][2]
               && row_loaded[j][3] && pose_known[parent_of[j]];
    endfunction

    function int known_parent();
        int p;
        p = $urandom_range(NJ - 1);
        return pose_known[p] ? p : 0;
    endfunction

    // whole joint: four offset rows in shuffled order, then its rotation
    task automatic joint_sequence();
        int j, par;
        int order [4];
        j   = $urandom_range(NJ - 1);
        par = known_parent();
        order = '{0, 1, 2, 3};
        order.shuffle();
        for (int k = 0; k < 4; k++)
            send_load(j, par, order[k], rand_q(), rand_q(), rand_q(), rand_q());
        send_rot(j, rand_q(), rand_q(), rand_q(), rand_q());
    endtask

    task automatic random_phase(int count);
        int sent, pick, j;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                joint_sequence();
                sent += 5;
            end
            else if (pick < 78)
            begin
                send_root(rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
                sent++;
            end
            else if (pick < 88)
            begin
                j = $urandom_range(NJ - 1);
                if (can_rotate(j))
                begin
                    send_rot(j, rand_q(), rand_q(), rand_q(), rand_q());
                    sent++;
                end
            end
            else if (pick < 94)
            begin
                send_load($urandom_range(NJ - 1), known_parent(), $urandom_range(3),
                          rand_q(), rand_q(), rand_q(), rand_q());
                sent++;
            end
            else
            begin
                send_item(filler(REQ_NONE));
                sent++;
            end
        end
    endtask

    // stop offering and wait for every expected row
    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        fork
            repeat (7) @(posedge clk);
        join
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: root poses with extreme values, unknown request
        send_root(32'sd65536, 32'sd131072, -32'sd196608, 32'sd65536, 32'sd0);
        send_root(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 32'sh7FFF_FFFF,
                  32'sh8000_0000);
        send_item(filler(REQ_NONE));
        send_root(32'sd0, 32'sd0, 32'sd0, 32'sd46341, 32'sd46341);
        // joint 1 under the root, identity offset with extreme translation
        send_load(1, 0, 0, 32'sd65536, 0, 0, 32'sh7FFF_FFFF);
        send_load(1, 0, 1, 0, 32'sd65536, 0, 32'sh8000_0000);
        send_load(1, 0, 2, 0, 0, 32'sd65536, -32'sd1);
        send_load(1, 0, 3, 0, 0, 0, 32'sd65536);
        send_rot(1, 32'sd65536, 0, 0, 0);
        send_rot(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_rot(1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        // joint zero rotated from its own stored parent (itself)
        for (int r = 0; r < 4; r++)
            send_load(0, 0, r, rand_q(), rand_q(), rand_q(), rand_q());
        send_rot(0, 32'sd46341, 0, 32'sd46341, 0);
        // last joint under joint 1, full-range content
        for (int r = 0; r < 4; r++)
            send_load(63, 1, r, $urandom, $urandom, $urandom, $urandom);
        send_rot(63, $urandom, $urandom, $urandom, $urandom);
        drain();

        // random phases with varied idling
        random_phase(25);
        drain();
        send_idle_pct = 72;
        random_phase(20);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 72;
        hold_asked++;
        random_phase(25);
        drain();
        send_idle_pct = 12;
        recv_stall_pct = 12;
        random_phase(25);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
